### rtl/dpsl_pkg.sv
package dpsl_pkg;

    // field widths
    localparam int CNT_W     = 16;
    localparam int ERR_W     = CNT_W + 1;
    localparam int GAIN_W    = 16;
    localparam int LIM_W     = 15;
    localparam int PER_W     = 8;
    localparam int PHASE_W   = 8;
    localparam int FRAC_W    = 8;
    localparam int INTEG_W   = LIM_W + FRAC_W + 1;
    localparam int PROD_W    = ERR_W + GAIN_W;
    localparam int ACC_W     = PROD_W + 1;
    localparam int QUO_W     = 25;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_TARGET = 3'd0;
    localparam t_cfg_idx CFG_GAIN_P = 3'd1;
    localparam t_cfg_idx CFG_GAIN_I = 3'd2;
    localparam t_cfg_idx CFG_ILIM   = 3'd3;
    localparam t_cfg_idx CFG_OLIM   = 3'd4;
    localparam t_cfg_idx CFG_PERIOD = 3'd5;

    localparam logic [LIM_W-1:0] LIMIT_RST  = 15'h7fff;
    localparam logic [PER_W-1:0] PERIOD_RST = 8'd10;

    localparam int DECIMATION_DEF = 10;

    typedef struct packed {
        logic signed [CNT_W-1:0] left_count;
        logic signed [CNT_W-1:0] right_count;
        logic                    drive_enable;
    } t_in_req;

    typedef struct packed {
        logic signed [CNT_W-1:0] drive_out;
        logic                    updated;
    } t_out_req;

    // status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

### rtl/dpsl_mul.sv
// Bit-serial signed x unsigned multiplier, one multiplier bit per cycle.
module dpsl_mul (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [dpsl_pkg::ERR_W-1:0]    i_a,
    input  logic        [dpsl_pkg::GAIN_W-1:0]   i_b,
    output dpsl_pkg::t_unit_stat                 o_stat,
    output logic signed [dpsl_pkg::PROD_W-1:0]   o_prod
);

    localparam int HW = dpsl_pkg::ERR_W + 2;
    localparam int BW = dpsl_pkg::GAIN_W;
    localparam int CW = $clog2(BW);

    logic signed [HW-1:0]              r_hi;
    logic        [BW-1:0]              r_lo;
    logic signed [dpsl_pkg::ERR_W-1:0] r_a;
    logic        [CW-1:0]              r_cnt;
    logic                              r_busy;
    logic                              r_done;

    logic signed [HW-1:0] a_ext;
    logic signed [HW-1:0] addend;
    logic signed [HW-1:0] part_sum;

    assign a_ext    = HW'(r_a);
    assign addend   = r_lo[0] ? a_ext : '0;
    assign part_sum = r_hi + addend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CW'(BW - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_hi  <= '0;
            r_lo  <= i_b;
            r_a   <= i_a;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_hi  <= part_sum >>> 1;
            r_lo  <= {part_sum[0], r_lo[BW-1:1]};
            r_cnt <= r_cnt + CW'(1);
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_prod      = {r_hi[dpsl_pkg::ERR_W-1:0], r_lo};

endmodule

### rtl/dpsl_div.sv
// Restoring divider, unsigned, one quotient bit per cycle.
module dpsl_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [dpsl_pkg::QUO_W-1:0]         i_num,
    input  logic [dpsl_pkg::PER_W-1:0]         i_den,
    output dpsl_pkg::t_unit_stat               o_stat,
    output logic [dpsl_pkg::QUO_W-1:0]         o_quo
);

    localparam int QW = dpsl_pkg::QUO_W;
    localparam int DW = dpsl_pkg::PER_W;
    localparam int CW = $clog2(QW);

    logic [QW-1:0] r_num;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [DW:0]   rem_sh;
    logic [DW+1:0] trial;
    logic          fits;

    assign rem_sh = {r_rem, r_num[QW-1]};
    assign trial  = {1'b0, rem_sh} - {2'b00, r_den};
    assign fits   = !trial[DW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CW'(QW - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[QW-2:0], fits};
            r_rem <= fits ? trial[DW-1:0] : rem_sh[DW-1:0];
            r_cnt <= r_cnt + CW'(1);
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_num;

endmodule

### rtl/decimated_pi_speed_loop.sv
// Decimated PI speed loop with linear output smoothing.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): one request per
// control tick with both encoder counts and the drive-enable flag.
// Output channel (o_out_valid / i_out_ready / o_out_data): exactly one
// request per tick, the smoothed drive value and an update flag.
// Config port: i_cfg_we writes i_cfg_data to register i_cfg_index at the
// clock edge; write only while no tick is in flight.
// All products run through one bit-serial multiplier (I term, P term,
// ramp) and the ramp division through one bit-serial restoring divider.
// The next tick is taken as soon as the current one has reached the
// output register. Reset (synchronous, active low) clears the tick phase,
// the integral, both stored outputs and the output valid flag, and loads
// the register defaults. If the receiver stalls, the result waits in the
// output register and one more tick can be computed behind it; that tick
// then holds in its final state until the output register frees up.
module decimated_pi_speed_loop #(
    parameter int unsigned DECIMATION = dpsl_pkg::DECIMATION_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  dpsl_pkg::t_in_req                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output dpsl_pkg::t_out_req                  o_out_data,
    input  logic                                i_cfg_we,
    input  dpsl_pkg::t_cfg_idx                  i_cfg_index,
    input  logic [dpsl_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int CNT_W   = dpsl_pkg::CNT_W;
    localparam int ERR_W   = dpsl_pkg::ERR_W;
    localparam int GAIN_W  = dpsl_pkg::GAIN_W;
    localparam int LIM_W   = dpsl_pkg::LIM_W;
    localparam int PER_W   = dpsl_pkg::PER_W;
    localparam int PHASE_W = dpsl_pkg::PHASE_W;
    localparam int FRAC_W  = dpsl_pkg::FRAC_W;
    localparam int INTEG_W = dpsl_pkg::INTEG_W;
    localparam int PROD_W  = dpsl_pkg::PROD_W;
    localparam int ACC_W   = dpsl_pkg::ACC_W;
    localparam int QUO_W   = dpsl_pkg::QUO_W;
    localparam int TOT_W   = QUO_W + 1;

    // sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_MUL_I   = 4'd1;   // err * gain_i
    localparam logic [3:0] S_I_CLAMP = 4'd2;   // clamp integral, start err * gain_p
    localparam logic [3:0] S_MUL_P   = 4'd3;
    localparam logic [3:0] S_P_CLAMP = 4'd4;   // clamp and round new output
    localparam logic [3:0] S_RAMP_GO = 4'd5;   // start diff * (phase + 1)
    localparam logic [3:0] S_RAMP    = 4'd6;
    localparam logic [3:0] S_DIV     = 4'd7;   // ramp / smooth_period
    localparam logic [3:0] S_HOLD    = 4'd8;   // result waits for output slot

    // configuration
    logic signed [CNT_W-1:0]  r_target;
    logic        [GAIN_W-1:0] r_gp;
    logic        [GAIN_W-1:0] r_gi;
    logic        [LIM_W-1:0]  r_ilim;
    logic        [LIM_W-1:0]  r_olim;
    logic        [PER_W-1:0]  r_period;

    // loop state
    logic        [PHASE_W-1:0] r_phase;
    logic signed [INTEG_W-1:0] r_integral;
    logic signed [CNT_W-1:0]   r_prev;
    logic signed [CNT_W-1:0]   r_newest;

    // per-tick work
    logic        [3:0]         r_state;
    logic signed [ERR_W-1:0]   r_err;
    logic                      r_drive;
    logic                      r_upd;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_neg;
    logic signed [CNT_W-1:0]   r_res;
    logic                      r_out_valid;
    dpsl_pkg::t_out_req        r_out;

    // arithmetic units
    logic                       mul_start;
    logic signed [ERR_W-1:0]    mul_a;
    logic        [GAIN_W-1:0]   mul_b;
    dpsl_pkg::t_unit_stat       mul_stat;
    logic signed [PROD_W-1:0]   mul_prod;

    logic                       div_start;
    logic [QUO_W-1:0]           div_num;
    logic [PER_W-1:0]           div_den;
    dpsl_pkg::t_unit_stat       div_stat;
    logic [QUO_W-1:0]           div_quo;

    // accept-time terms
    logic                       in_acc;
    logic [PHASE_W:0]           next_phase;
    logic                       upd_now;
    logic signed [ERR_W-1:0]    in_diff;
    logic signed [CNT_W-1:0]    speed;
    logic signed [ERR_W-1:0]    err_in;

    logic signed [ACC_W-1:0]    acc_sum;
    logic signed [INTEG_W-1:0]  out_sat;
    logic signed [INTEG_W:0]    out_rnd;
    logic signed [ERR_W-1:0]    ramp_diff;
    logic signed [PROD_W-1:0]   ramp_mag;
    logic signed [TOT_W-1:0]    prev_ext;
    logic signed [TOT_W-1:0]    quo_ext;
    logic signed [TOT_W-1:0]    total;
    logic                       out_load;

    function automatic logic signed [INTEG_W-1:0] clamp_lim(
        input logic signed [ACC_W-1:0] v,
        input logic [LIM_W-1:0]        lim
    );
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = $signed(ACC_W'({lim, {FRAC_W{1'b0}}}));
        lo = -hi;
        if (v > hi) begin
            clamp_lim = INTEG_W'(hi);
        end else if (v < lo) begin
            clamp_lim = INTEG_W'(lo);
        end else begin
            clamp_lim = INTEG_W'(v);
        end
    endfunction

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    assign next_phase = {1'b0, r_phase} + (PHASE_W + 1)'(1);
    assign upd_now    = next_phase >= (PHASE_W + 1)'(DECIMATION);

    // speed = (left + (-right)) >>> 1, error = target - speed
    assign in_diff = ERR_W'(i_in_data.left_count) - ERR_W'(i_in_data.right_count);
    assign speed   = in_diff[ERR_W-1:1];
    assign err_in  = ERR_W'(r_target) - ERR_W'(speed);

    // shared by the I step (old integral) and the P step (new integral)
    assign acc_sum = ACC_W'(r_integral) + ACC_W'(mul_prod);

    // round half up after the output clamp
    assign out_sat = clamp_lim(r_acc, r_olim);
    assign out_rnd = (INTEG_W + 1)'(out_sat) + (INTEG_W + 1)'(1 << (FRAC_W - 1));

    assign ramp_diff = ERR_W'(r_newest) - ERR_W'(r_prev);
    assign ramp_mag  = mul_prod[PROD_W-1] ? -mul_prod : mul_prod;

    // quotient truncates toward zero: apply the sign to the magnitude
    assign prev_ext = TOT_W'(r_prev);
    assign quo_ext  = $signed({1'b0, div_quo});
    assign total    = r_neg ? (prev_ext - quo_ext) : (prev_ext + quo_ext);

    assign out_load = (r_state == S_HOLD) && (!r_out_valid || i_out_ready);

    // multiplier operand select
    always_comb begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (r_state)
            S_IDLE: begin
                mul_start = in_acc && upd_now;
                mul_a     = err_in;
                mul_b     = r_gi;
            end
            S_I_CLAMP: begin
                mul_start = 1'b1;
                mul_a     = r_err;
                mul_b     = r_gp;
            end
            S_RAMP_GO: begin
                mul_start = 1'b1;
                mul_a     = ramp_diff;
                mul_b     = GAIN_W'(r_phase) + GAIN_W'(1);
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    assign div_start = (r_state == S_RAMP) && mul_stat.done;
    assign div_num   = ramp_mag[QUO_W-1:0];
    assign div_den   = (r_period == '0) ? PER_W'(1) : r_period;

    dpsl_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_stat  (mul_stat),
        .o_prod  (mul_prod)
    );

    dpsl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat),
        .o_quo   (div_quo)
    );

    // configuration registers; upper data bits beyond a field are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_gp     <= '0;
            r_gi     <= '0;
            r_ilim   <= dpsl_pkg::LIMIT_RST;
            r_olim   <= dpsl_pkg::LIMIT_RST;
            r_period <= dpsl_pkg::PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dpsl_pkg::CFG_TARGET: r_target <= $signed(i_cfg_data[CNT_W-1:0]);
                dpsl_pkg::CFG_GAIN_P: r_gp     <= i_cfg_data[GAIN_W-1:0];
                dpsl_pkg::CFG_GAIN_I: r_gi     <= i_cfg_data[GAIN_W-1:0];
                dpsl_pkg::CFG_ILIM:   r_ilim   <= i_cfg_data[LIM_W-1:0];
                dpsl_pkg::CFG_OLIM:   r_olim   <= i_cfg_data[LIM_W-1:0];
                dpsl_pkg::CFG_PERIOD: r_period <= i_cfg_data[PER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_phase    <= '0;
            r_integral <= '0;
            r_prev     <= '0;
            r_newest   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (upd_now) begin
                            r_phase <= '0;
                            r_prev  <= r_newest;
                            r_state <= S_MUL_I;
                        end else begin
                            r_phase <= next_phase[PHASE_W-1:0];
                            r_state <= S_RAMP_GO;
                        end
                    end
                end
                S_MUL_I: begin
                    if (mul_stat.done) begin
                        r_state <= S_I_CLAMP;
                    end
                end
                S_I_CLAMP: begin
                    r_integral <= r_drive ? clamp_lim(r_acc, r_ilim) : '0;
                    r_state    <= S_MUL_P;
                end
                S_MUL_P: begin
                    if (mul_stat.done) begin
                        r_state <= S_P_CLAMP;
                    end
                end
                S_P_CLAMP: begin
                    r_newest <= out_rnd[INTEG_W-1:FRAC_W];
                    r_state  <= S_RAMP_GO;
                end
                S_RAMP_GO: begin
                    r_state <= S_RAMP;
                end
                S_RAMP: begin
                    if (mul_stat.done) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // per-tick datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_err   <= err_in;
            r_drive <= i_in_data.drive_enable;
            r_upd   <= upd_now;
        end
        if ((r_state == S_MUL_I || r_state == S_MUL_P) && mul_stat.done) begin
            r_acc <= acc_sum;
        end
        if (div_start) begin
            r_neg <= mul_prod[PROD_W-1];
        end
        if (r_state == S_DIV && div_stat.done) begin
            if (total > TOT_W'(32767)) begin
                r_res <= 16'sh7fff;
            end else if (total < -TOT_W'(32768)) begin
                r_res <= 16'sh8000;
            end else begin
                r_res <= total[CNT_W-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.drive_out <= r_res;
            r_out.updated   <= r_upd;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_phase} < (PHASE_W + 1)'(DECIMATION)))
        else $error("tick phase reached decimation");

    a_integral_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL_P) |->
            (r_integral <= $signed(INTEG_W'({r_ilim, {FRAC_W{1'b0}}}))) &&
            (r_integral >= -$signed(INTEG_W'({r_ilim, {FRAC_W{1'b0}}}))))
        else $error("integral outside its limit");

    a_units_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!mul_stat.busy && !div_stat.busy))
        else $error("arithmetic unit busy while idle");

    a_out_from_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_HOLD))
        else $error("result loaded outside hold state");
`endif

endmodule

### tb/sv/tb_decimated_pi_speed_loop.sv
module tb_decimated_pi_speed_loop;

    import dpsl_pkg::*;

    // Spare register indexes; writes there must leave every register alone.
    localparam t_cfg_idx CFG_SPARE_LO = 3'd6;
    localparam t_cfg_idx CFG_SPARE_HI = 3'd7;

    localparam longint DECIM      = DECIMATION_DEF;
    // Longest quiet stretch is the deliberate receiver hold-off plus one
    // PI update tick; this is several times that.
    localparam int     QUIET_MAX  = 3000;
    localparam int     HOLD_LEN   = 400;
    localparam int     TAIL_WAIT  = 120;
    localparam int     RAND_SETS  = 12;
    localparam int     SET_TICKS  = 90;

    logic                  clk;
    logic                  rst_n;
    logic                  tick_valid;
    logic                  tick_ready;
    t_in_req               tick_data;
    logic                  res_valid;
    logic                  res_ready;
    t_out_req              res_data;
    logic                  cfg_we;
    t_cfg_idx              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    decimated_pi_speed_loop DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (tick_valid),
        .o_in_ready  (tick_ready),
        .i_in_data   (tick_data),
        .o_out_valid (res_valid),
        .i_out_ready (res_ready),
        .o_out_data  (res_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the loop: registers at their widths, plus state.
    // ------------------------------------------------------------------
    logic signed [15:0] sh_target;
    logic [15:0]        sh_gain_p;
    logic [15:0]        sh_gain_i;
    logic [14:0]        sh_ilim;
    logic [14:0]        sh_olim;
    logic [7:0]         sh_period;

    logic [7:0]         sh_phase;
    logic signed [23:0] sh_integral;
    logic signed [15:0] sh_prev_out;
    logic signed [15:0] sh_new_out;

    t_out_req drive_expected[$];
    int       mismatch_cnt;
    int       quiet_cycles;

    // Stimulus knobs, changed between test sets.
    bit tx_idle;
    bit rx_idle;
    int rx_hold_len;

    function automatic logic signed [15:0] sat16(longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    // One control tick through the shadow loop: phase step, PI update on
    // the decimation boundary, then the ramp between the stored outputs.
    function automatic t_out_req predict_drive(t_in_req req);
        longint   left;
        longint   right;
        longint   nxt;
        longint   speed;
        longint   err;
        longint   acc;
        longint   sum;
        longint   ilim;
        longint   olim;
        longint   per;
        longint   diff;
        longint   ramp;
        t_out_req r;
        left      = longint'(req.left_count);
        right     = longint'(req.right_count);
        nxt       = longint'(sh_phase) + 1;
        r.updated = 1'b0;
        if (nxt >= DECIM) begin
            // right count arrives raw, so left - right is the pulse sum
            speed = (left - right) >>> 1;
            err   = longint'(sh_target) - speed;
            ilim  = longint'(sh_ilim) * 256;
            olim  = longint'(sh_olim) * 256;
            acc   = longint'(sh_integral) + err * longint'(sh_gain_i);
            if (!req.drive_enable)
                acc = 0;
            if (acc > ilim)
                acc = ilim;
            else if (acc < -ilim)
                acc = -ilim;
            sh_integral = acc[23:0];
            sum = err * longint'(sh_gain_p) + acc;
            if (sum > olim)
                sum = olim;
            else if (sum < -olim)
                sum = -olim;
            sh_prev_out = sh_new_out;
            sh_new_out  = sat16((sum + 128) >>> 8);
            sh_phase    = 8'd0;
            r.updated   = 1'b1;
        end else begin
            sh_phase = nxt[7:0];
        end
        per = (sh_period == 8'd0) ? 1 : longint'(sh_period);
        diff = longint'(sh_new_out) - longint'(sh_prev_out);
        // SV division truncates toward zero, as the ramp requires
        ramp = diff * (longint'(sh_phase) + 1) / per;
        r.drive_out = sat16(ramp + longint'(sh_prev_out));
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock and reset: reset applied once, at the start.
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        rst_n      = 1'b0;
        tick_valid = 1'b0;
        tick_data  = '0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_TARGET;
        cfg_data   = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Receiver: random stall per result, or one long hold-off on request.
    // Ready is only lowered in the step of an accept or before a wait.
    // ------------------------------------------------------------------
    initial begin : receiver
        int n;
        res_ready = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever begin
            if (rx_hold_len > 0) begin
                res_ready <= 1'b0;
                repeat (rx_hold_len) @(posedge clk);
                rx_hold_len = 0;
            end else begin
                n = rx_idle ? $urandom_range(0, 8) : 0;
                if (n > 0) begin
                    res_ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
            end
            res_ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_valid);
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard: sample both channels at the edge, pre-edge values.
    // Results are checked before this edge's input request is predicted.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : scoreboard
        t_out_req want;
        if (rst_n) begin
            if (res_valid && res_ready) begin
                if (drive_expected.size() == 0) begin
                    $error("unexpected result: drive_out=%0d updated=%0b",
                           res_data.drive_out, res_data.updated);
                    mismatch_cnt++;
                end else begin
                    want = drive_expected.pop_front();
                    if (res_data.drive_out !== want.drive_out) begin
                        $error("drive_out: expected %0d, got %0d",
                               want.drive_out, res_data.drive_out);
                        mismatch_cnt++;
                    end
                    if (res_data.updated !== want.updated) begin
                        $error("updated: expected %0b, got %0b",
                               want.updated, res_data.updated);
                        mismatch_cnt++;
                    end
                end
            end
            if (tick_valid && tick_ready)
                drive_expected.push_back(predict_drive(tick_data));
        end
    end

    // Watchdog: too long with no request moving on either channel.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((tick_valid && tick_ready) || (res_valid && res_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_MAX) begin
                $display("decimated_pi_speed_loop: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared tasks
    // ------------------------------------------------------------------

    // Register write; the shadow copy applies the same width masking.
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_TARGET: sh_target = val;
            CFG_GAIN_P: sh_gain_p = val;
            CFG_GAIN_I: sh_gain_i = val;
            CFG_ILIM:   sh_ilim   = val[14:0];
            CFG_OLIM:   sh_olim   = val[14:0];
            CFG_PERIOD: sh_period = val[7:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Sender stops until every predicted result has been checked. The first
    // edge lets the scoreboard log a request accepted at the current edge.
    task automatic wait_drained();
        @(posedge clk);
        while (drive_expected.size() != 0)
            @(posedge clk);
    endtask

    // Offer a burst of ticks. Valid stays up across back-to-back requests
    // and is dropped only for a gap or once the burst is done.
    task automatic send_ticks(t_in_req ticks[$]);
        int gap;
        foreach (ticks[k]) begin
            gap = tx_idle ? $urandom_range(0, 8) : 0;
            if (gap > 0) begin
                tick_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            tick_valid <= 1'b1;
            tick_data  <= ticks[k];
            do
                @(posedge clk);
            while (!tick_ready);
        end
        tick_valid <= 1'b0;
    endtask

    // Mostly counts near the target speed so the loop stays out of the
    // clamps; the rest spans the full count range.
    function automatic t_in_req make_tick(bit full_range);
        t_in_req t;
        longint  base;
        if (full_range) begin
            t.left_count  = 16'($urandom);
            t.right_count = 16'($urandom);
        end else begin
            base = longint'(sh_target) + longint'(int'($urandom_range(0, 64)) - 32);
            t.left_count  = sat16(base + longint'(int'($urandom_range(0, 16)) - 8));
            t.right_count = sat16(-base + longint'(int'($urandom_range(0, 16)) - 8));
        end
        t.drive_enable = ($urandom_range(0, 15) != 0);
        return t;
    endfunction

    function automatic t_in_req tick_of(logic signed [15:0] l, logic signed [15:0] r,
                                         logic drv);
        t_in_req t;
        t.left_count   = l;
        t.right_count  = r;
        t.drive_enable = drv;
        return t;
    endfunction

    // kind 0: all low extremes, 1: all high extremes, else random.
    task automatic load_settings(int kind);
        logic [15:0] t;
        logic [15:0] gp;
        logic [15:0] gi;
        logic [14:0] il;
        logic [14:0] ol;
        logic [7:0]  per;
        case (kind)
            0: begin
                t = 16'h8000; gp = '0; gi = '0; il = '0; ol = '0; per = 8'd0;
            end
            1: begin
                t = 16'h7fff; gp = 16'hffff; gi = 16'hffff;
                il = 15'h7fff; ol = 15'h7fff; per = 8'd255;
            end
            default: begin
                t = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                : 16'(int'($urandom_range(0, 2000)) - 1000);
                gp = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(0, 16'h0600));
                gi = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(0, 16'h0100));
                il = ($urandom_range(0, 3) == 0) ? 15'($urandom)
                                                 : 15'($urandom_range(0, 600));
                ol = ($urandom_range(0, 3) == 0) ? 15'($urandom)
                                                 : 15'($urandom_range(0, 2000));
                // periods below the decimation let the ramp overshoot
                per = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 3))
                                                  : 8'($urandom_range(4, 40));
            end
        endcase
        write_reg(CFG_TARGET, t);
        write_reg(CFG_GAIN_P, gp);
        write_reg(CFG_GAIN_I, gi);
        // junk above the register width must be dropped
        write_reg(CFG_ILIM, {1'($urandom), il});
        write_reg(CFG_OLIM, {1'($urandom), ol});
        write_reg(CFG_PERIOD, {8'($urandom), per});
        write_reg(CFG_SPARE_LO, 16'($urandom));
        write_reg(CFG_SPARE_HI, 16'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Count extremes, reset defaults, zero period, wide writes, spare
    // indexes, integral clear with drive off, and ramp overshoot.
    task automatic test_directed();
        t_in_req ticks[$];
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        // four ticks on the reset defaults
        ticks = {tick_of(16'sh7fff, 16'sh8000, 1'b1), tick_of(16'sh8000, 16'sh7fff, 1'b1),
                 tick_of(16'sh0000, 16'sh0000, 1'b0), tick_of(16'shffff, 16'sh0001, 1'b1)};
        send_ticks(ticks);
        wait_drained();
        // max gains, wide limit write, period write that lands on zero
        write_reg(CFG_TARGET, 16'h8000);
        write_reg(CFG_GAIN_P, 16'hffff);
        write_reg(CFG_GAIN_I, 16'hffff);
        write_reg(CFG_ILIM, 16'hffff);
        write_reg(CFG_OLIM, 16'h7fff);
        write_reg(CFG_PERIOD, 16'hab00);
        write_reg(CFG_SPARE_LO, 16'h5a5a);
        write_reg(CFG_SPARE_HI, 16'hffff);
        ticks = {tick_of(16'sh0001, 16'sh0000, 1'b1), tick_of(16'sh8000, 16'sh0001, 1'b1),
                 tick_of(16'sh1234, 16'shedcb, 1'b1), tick_of(16'sh0000, 16'shffff, 1'b1),
                 tick_of(16'sh7ffe, 16'sh8001, 1'b1),
                 // update tick: full speed, drive off clears the integral
                 tick_of(16'sh7fff, 16'sh8000, 1'b0)};
        send_ticks(ticks);
        wait_drained();
        // swing to the other rail with period 1 so the ramp overshoots
        write_reg(CFG_TARGET, 16'h7fff);
        write_reg(CFG_GAIN_I, 16'h0001);
        write_reg(CFG_ILIM, 16'h8000);
        write_reg(CFG_PERIOD, 16'h0001);
        ticks.delete();
        repeat (9)
            ticks.push_back(make_tick(1'b1));
        ticks.push_back(tick_of(16'sh8000, 16'sh7fff, 1'b1));
        send_ticks(ticks);
        wait_drained();
    endtask

    // Receiver holds off while the sender keeps offering: the block fills
    // its output register and one more tick, then stalls its input.
    task automatic test_backpressure();
        t_in_req ticks[$];
        load_settings(2);
        tx_idle     = 1'b0;
        rx_idle     = 1'b0;
        rx_hold_len = HOLD_LEN;
        repeat (30)
            ticks.push_back(make_tick($urandom_range(0, 3) == 0));
        send_ticks(ticks);
        wait_drained();
    endtask

    // Several register settings, extremes first, random ticks in each.
    task automatic test_random_settings();
        t_in_req ticks[$];
        for (int s = 0; s < RAND_SETS; s++) begin
            load_settings(s);
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            ticks.delete();
            repeat (SET_TICKS)
                ticks.push_back(make_tick($urandom_range(0, 3) == 0));
            send_ticks(ticks);
            wait_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        mismatch_cnt = 0;
        quiet_cycles = 0;
        rx_hold_len  = 0;
        tx_idle      = 1'b0;
        rx_idle      = 1'b0;
        // shadow reset state
        sh_target    = '0;
        sh_gain_p    = '0;
        sh_gain_i    = '0;
        sh_ilim      = LIMIT_RST;
        sh_olim      = LIMIT_RST;
        sh_period    = PERIOD_RST;
        sh_phase     = '0;
        sh_integral  = '0;
        sh_prev_out  = '0;
        sh_new_out   = '0;
        while (!rst_n)
            @(posedge clk);
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_random_settings();

        wait_drained();
        // let any stray late result show up before the verdict
        repeat (TAIL_WAIT) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("decimated_pi_speed_loop: match");
        else
            $display("decimated_pi_speed_loop: mismatch");
        $finish;
    end

endmodule
